@@ sv/gda_pkg.sv @@
// Shared types, constants and calendar helpers for the Gregorian date unit.
// No dependencies; used by every module of the block.
package gda_pkg;

  // Calendar limits
  localparam int unsigned MAX_YEAR   = 4095;
  localparam int unsigned EPOCH_YEAR = 1970;

  // Walker widths: the year counter holds one past MAX_YEAR to flag overflow
  localparam int unsigned YEAR_W = 13;
  localparam int unsigned CNT_W  = 20;

  localparam logic [YEAR_W-1:0] MAX_YEAR_W   = YEAR_W'(MAX_YEAR);
  localparam logic [YEAR_W-1:0] EPOCH_YEAR_W = YEAR_W'(EPOCH_YEAR);

  // Residues of the epoch year for the leap-year counters
  localparam logic [1:0] EPOCH_MOD4   = 2'(EPOCH_YEAR % 4);
  localparam logic [6:0] EPOCH_MOD100 = 7'(EPOCH_YEAR % 100);
  localparam logic [8:0] EPOCH_MOD400 = 9'(EPOCH_YEAR % 400);

  localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } gda_status_t;

  typedef struct packed {
    logic        action;
    logic [4:0]  a_day;
    logic [3:0]  a_month;
    logic [11:0] a_year;
    logic [4:0]  b_day;
    logic [3:0]  b_month;
    logic [11:0] b_year;
    logic [15:0] add_days;
  } gda_in_t;

  typedef struct packed {
    logic [19:0] day_difference;
    logic [4:0]  sum_day;
    logic [3:0]  sum_month;
    logic [11:0] sum_year;
    gda_status_t status;
  } gda_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_YEARS,
    S_CHECK,
    S_MONTHS,
    S_ADD_YEARS,
    S_ADD_MONTHS,
    S_DONE
  } gda_state_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_YEAR_ADD,
    OP_ENTER_MONTHS,
    OP_MONTH_ADD,
    OP_SAVE_A,
    OP_FIN_DIFF,
    OP_START_ADD,
    OP_YEAR_SUB,
    OP_MONTH_SUB,
    OP_FIN_SUM,
    OP_FIN_OVF,
    OP_FIN_INVALID
  } gda_op_t;

  typedef struct packed {
    gda_op_t op;
  } gda_cmd_t;

  typedef struct packed {
    logic action;       // item asks for an add
    logic sel_b;        // walker is on date B
    logic year_below;   // walker year below the target year
    logic date_valid;   // target date in range
    logic month_below;  // walker month below the target month
    logic year_fits;    // remainder covers the current year
    logic month_fits;   // remainder covers the current month
    logic overflow;     // walker year past MAX_YEAR
  } gda_stat_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                       len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

endpackage

@@ sv/gda_datapath.sv @@
// Datapath of the date unit: item register, year/month walker, accumulators, result.
// Depends on gda_pkg; driven by gda_controller through gda_cmd_t.
module gda_datapath (
  input  logic              clk,
  input  logic              rst,
  input  gda_pkg::gda_in_t  item,
  input  gda_pkg::gda_cmd_t cmd,
  output gda_pkg::gda_stat_t stat,
  output gda_pkg::gda_out_t result
);

  gda_pkg::gda_in_t   item_q;
  logic               sel_b;
  logic [gda_pkg::YEAR_W-1:0] y;
  logic [1:0]         c4;
  logic [6:0]         c100;
  logic [8:0]         c400;
  logic [3:0]         m;
  logic [gda_pkg::CNT_W-1:0] n;
  logic [gda_pkg::CNT_W-1:0] na;
  gda_pkg::gda_out_t  res;

  logic                sel_b_next;
  logic [gda_pkg::YEAR_W-1:0] y_next;
  logic [1:0]          c4_next;
  logic [6:0]          c100_next;
  logic [8:0]          c400_next;
  logic [3:0]          m_next;
  logic [gda_pkg::CNT_W-1:0] n_next;
  logic [gda_pkg::CNT_W-1:0] na_next;
  gda_pkg::gda_out_t   res_next;

  logic        leap;
  logic [4:0]  tgt_day;
  logic [3:0]  tgt_month;
  logic [11:0] tgt_year;
  logic [4:0]  cur_mlen;
  logic [8:0]  cur_ylen;
  logic [4:0]  tgt_mlen;
  logic [gda_pkg::CNT_W-1:0] day_m1;
  logic [gda_pkg::CNT_W-1:0] idx_now;
  logic [gda_pkg::CNT_W-1:0] diff;

  // Leap flag of the walker year from its residues
  assign leap = ((c4 == 2'd0) && (c100 != 7'd0)) || (c400 == 9'd0);

  // Select the date under walk
  assign tgt_day   = sel_b ? item_q.b_day   : item_q.a_day;
  assign tgt_month = sel_b ? item_q.b_month : item_q.a_month;
  assign tgt_year  = sel_b ? item_q.b_year  : item_q.a_year;

  assign cur_mlen = gda_pkg::month_len(m, leap);
  assign cur_ylen = gda_pkg::year_len(leap);
  assign tgt_mlen = gda_pkg::month_len(tgt_month, leap);
  assign day_m1   = gda_pkg::CNT_W'(tgt_day) - gda_pkg::CNT_W'(1);
  assign idx_now  = n + day_m1;
  assign diff     = (na >= idx_now) ? (na - idx_now) : (idx_now - na);

  // Status back to the controller
  always_comb begin
    stat.action      = item_q.action;
    stat.sel_b       = sel_b;
    stat.year_below  = y < {1'b0, tgt_year};
    stat.date_valid  = ({1'b0, tgt_year} >= gda_pkg::EPOCH_YEAR_W) &&
                       ({1'b0, tgt_year} <= gda_pkg::MAX_YEAR_W) &&
                       (tgt_month != 4'd0) && (tgt_month <= gda_pkg::MONTHS_PER_YEAR) &&
                       (tgt_day != 5'd0) && (tgt_day <= tgt_mlen);
    stat.month_below = m < tgt_month;
    stat.overflow    = y > gda_pkg::MAX_YEAR_W;
    stat.year_fits   = !stat.overflow && (n >= gda_pkg::CNT_W'(cur_ylen));
    stat.month_fits  = (m < gda_pkg::MONTHS_PER_YEAR) && (n >= gda_pkg::CNT_W'(cur_mlen));
  end

  // Next values per operation
  always_comb begin
    sel_b_next = sel_b;
    y_next     = y;
    c4_next    = c4;
    c100_next  = c100;
    c400_next  = c400;
    m_next     = m;
    n_next     = n;
    na_next    = na;
    res_next   = res;
    unique case (cmd.op)
      gda_pkg::OP_LOAD, gda_pkg::OP_SAVE_A: begin
        sel_b_next = (cmd.op == gda_pkg::OP_SAVE_A);
        y_next     = gda_pkg::EPOCH_YEAR_W;
        c4_next    = gda_pkg::EPOCH_MOD4;
        c100_next  = gda_pkg::EPOCH_MOD100;
        c400_next  = gda_pkg::EPOCH_MOD400;
        m_next     = 4'd1;
        n_next     = '0;
        if (cmd.op == gda_pkg::OP_SAVE_A) begin
          na_next = idx_now;
        end
      end
      gda_pkg::OP_YEAR_ADD, gda_pkg::OP_YEAR_SUB: begin
        n_next    = (cmd.op == gda_pkg::OP_YEAR_ADD) ? n + gda_pkg::CNT_W'(cur_ylen)
                                                     : n - gda_pkg::CNT_W'(cur_ylen);
        y_next    = y + gda_pkg::YEAR_W'(1);
        c4_next   = c4 + 2'd1;
        c100_next = (c100 == 7'd99)  ? 7'd0 : c100 + 7'd1;
        c400_next = (c400 == 9'd399) ? 9'd0 : c400 + 9'd1;
      end
      gda_pkg::OP_ENTER_MONTHS: begin
        // an add counts from the start of A's year
        if (item_q.action) begin
          n_next = '0;
        end
      end
      gda_pkg::OP_MONTH_ADD: begin
        n_next = n + gda_pkg::CNT_W'(cur_mlen);
        m_next = m + 4'd1;
      end
      gda_pkg::OP_MONTH_SUB: begin
        n_next = n - gda_pkg::CNT_W'(cur_mlen);
        m_next = m + 4'd1;
      end
      gda_pkg::OP_START_ADD: begin
        n_next = idx_now + gda_pkg::CNT_W'(item_q.add_days);
        m_next = 4'd1;
      end
      gda_pkg::OP_FIN_DIFF: begin
        res_next = '0;
        res_next.day_difference = diff;
        res_next.status = gda_pkg::ST_OK;
      end
      gda_pkg::OP_FIN_SUM: begin
        res_next.day_difference = '0;
        res_next.sum_day   = n[4:0] + 5'd1;
        res_next.sum_month = m;
        res_next.sum_year  = y[11:0];
        res_next.status    = gda_pkg::ST_OK;
      end
      gda_pkg::OP_FIN_OVF: begin
        res_next.day_difference = '0;
        res_next.sum_day   = 5'd31;
        res_next.sum_month = gda_pkg::MONTHS_PER_YEAR;
        res_next.sum_year  = gda_pkg::MAX_YEAR_W[11:0];
        res_next.status    = gda_pkg::ST_OVERFLOW;
      end
      gda_pkg::OP_FIN_INVALID: begin
        res_next = '0;
        res_next.status = gda_pkg::ST_INVALID;
      end
      default: begin
      end
    endcase
  end

  // Hold the item on load
  always_ff @(posedge clk) begin
    if (cmd.op == gda_pkg::OP_LOAD) begin
      item_q <= item;
    end
  end

  // Walker and result registers
  always_ff @(posedge clk) begin
    sel_b <= sel_b_next;
    y     <= y_next;
    c4    <= c4_next;
    c100  <= c100_next;
    c400  <= c400_next;
    m     <= m_next;
    n     <= n_next;
    na    <= na_next;
    res   <= res_next;
  end

  assign result = res;

`ifndef SYNTHESIS
  a_sum_day_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.op == gda_pkg::OP_FIN_SUM |=> (res.sum_day != 5'd0) && (res.status == gda_pkg::ST_OK))
    else $error("finished sum carries no day of month");
  a_year_sub_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.op == gda_pkg::OP_YEAR_SUB |-> y <= gda_pkg::MAX_YEAR_W)
    else $error("year step taken past the last year");
  a_load_epoch: assert property (@(posedge clk) disable iff (rst)
    cmd.op == gda_pkg::OP_LOAD |=> (y == gda_pkg::EPOCH_YEAR_W) && (n == '0) && !sel_b)
    else $error("walker not reset to the epoch on load");
`endif

endmodule

@@ sv/gda_controller.sv @@
// Controller of the date unit: sequences the year and month walks of the datapath.
// Depends on gda_pkg; drives gda_datapath through gda_cmd_t.
module gda_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  gda_pkg::gda_stat_t stat,
  output gda_pkg::gda_cmd_t  cmd,
  output logic               busy,
  output logic               done
);

  gda_pkg::gda_state_t state;
  gda_pkg::gda_state_t state_next;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gda_pkg::S_IDLE: begin
        if (start) state_next = gda_pkg::S_YEARS;
      end
      gda_pkg::S_YEARS: begin
        if (!stat.year_below) state_next = gda_pkg::S_CHECK;
      end
      gda_pkg::S_CHECK: begin
        state_next = stat.date_valid ? gda_pkg::S_MONTHS : gda_pkg::S_DONE;
      end
      gda_pkg::S_MONTHS: begin
        if (!stat.month_below) begin
          if (stat.action)      state_next = gda_pkg::S_ADD_YEARS;
          else if (!stat.sel_b) state_next = gda_pkg::S_YEARS;
          else                  state_next = gda_pkg::S_DONE;
        end
      end
      gda_pkg::S_ADD_YEARS: begin
        if (!stat.year_fits) begin
          state_next = stat.overflow ? gda_pkg::S_DONE : gda_pkg::S_ADD_MONTHS;
        end
      end
      gda_pkg::S_ADD_MONTHS: begin
        if (!stat.month_fits) state_next = gda_pkg::S_DONE;
      end
      gda_pkg::S_DONE: begin
        state_next = gda_pkg::S_IDLE;
      end
      default: state_next = gda_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd.op = gda_pkg::OP_NONE;
    busy   = 1'b1;
    done   = 1'b0;
    unique case (state)
      gda_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) cmd.op = gda_pkg::OP_LOAD;
      end
      gda_pkg::S_YEARS: begin
        if (stat.year_below) cmd.op = gda_pkg::OP_YEAR_ADD;
      end
      gda_pkg::S_CHECK: begin
        cmd.op = stat.date_valid ? gda_pkg::OP_ENTER_MONTHS : gda_pkg::OP_FIN_INVALID;
      end
      gda_pkg::S_MONTHS: begin
        if (stat.month_below)  cmd.op = gda_pkg::OP_MONTH_ADD;
        else if (stat.action)  cmd.op = gda_pkg::OP_START_ADD;
        else if (!stat.sel_b)  cmd.op = gda_pkg::OP_SAVE_A;
        else                   cmd.op = gda_pkg::OP_FIN_DIFF;
      end
      gda_pkg::S_ADD_YEARS: begin
        if (stat.year_fits)     cmd.op = gda_pkg::OP_YEAR_SUB;
        else if (stat.overflow) cmd.op = gda_pkg::OP_FIN_OVF;
      end
      gda_pkg::S_ADD_MONTHS: begin
        cmd.op = stat.month_fits ? gda_pkg::OP_MONTH_SUB : gda_pkg::OP_FIN_SUM;
      end
      gda_pkg::S_DONE: begin
        done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gda_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted beat did not start a walk");
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(cmd.op) == gda_pkg::OP_FIN_DIFF) ||
             ($past(cmd.op) == gda_pkg::OP_FIN_SUM) ||
             ($past(cmd.op) == gda_pkg::OP_FIN_OVF) ||
             ($past(cmd.op) == gda_pkg::OP_FIN_INVALID))
    else $error("result strobe without a finished result");
`endif

endmodule

@@ sv/gregorian_date_arithmetic_unit.sv @@
// Top level of the Gregorian date unit: controller plus datapath.
// Depends on gda_pkg, gda_controller and gda_datapath.
//
// A beat is taken when start is high and busy is low; one result beat follows,
// shown on result with done high for exactly one cycle, and it cannot be held
// off. Each date is walked year by year from 1970 and then month by month in
// one shared walker, one step per cycle. A day difference walks date A and then
// date B; an add walks date A and then the whole years and months added, and
// ends with an overflow status if the sum passes year 4095. An invalid date ends
// after its year walk. busy stays high from acceptance through the result cycle.
module gregorian_date_arithmetic_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  gda_pkg::gda_in_t  item,
  output logic              busy,
  output logic              done,
  output gda_pkg::gda_out_t result
);

  gda_pkg::gda_cmd_t  cmd;
  gda_pkg::gda_stat_t stat;

  gda_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  gda_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

endmodule
